// ===== design/adc_two_point_cal_moving_average_defines.svh =====
// Assertion macros shared by the calibration channel.
// Each macro expands to one labelled concurrent assertion on the rising clock edge,
// disabled while the synchronous active-low reset is asserted.
`ifndef ADC_TWO_POINT_CAL_MOVING_AVERAGE_DEFINES_SVH
`define ADC_TWO_POINT_CAL_MOVING_AVERAGE_DEFINES_SVH

// Same-cycle implication.
`define ADCCAL_ASSERT_NOW(label, clk, rst_n, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication.
`define ADCCAL_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ===== design/adccal_pkg.sv =====
// ----------------------------------------------------------------------------
// adccal_pkg
// Widths and register indexes of the two-point calibration channel.
// ----------------------------------------------------------------------------
package adccal_pkg;

  // Width of a calibrated value and of the calibration values.
  localparam int VAL_W      = 16;
  // Width of the raw calibration points.
  localparam int RAWCAL_W   = 10;
  // Configuration port widths.
  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = 16;

  // Register indexes of the configuration port.
  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_RAW_CAL_LOW    = 3'd0,
    CFG_RAW_CAL_HIGH   = 3'd1,
    CFG_VALUE_AT_LOW   = 3'd2,
    CFG_VALUE_AT_HIGH  = 3'd3,
    CFG_AVERAGE_BYPASS = 3'd4
  } cfg_idx_t;

endpackage

// ===== design/adccal_if.sv =====
// ----------------------------------------------------------------------------
// adccal_in_if / adccal_out_if
// Valid/ready channels for raw samples and calibrated results.
// ----------------------------------------------------------------------------

// Raw sample channel.
interface adccal_in_if #(
  parameter int SAMPLE_BITS = 10
);
  logic                   valid;
  logic                   ready;
  logic [SAMPLE_BITS-1:0] raw_sample;

  modport source (output valid, output raw_sample, input ready);
  modport sink   (input valid, input raw_sample, output ready);
endinterface

// Result channel.
interface adccal_out_if import adccal_pkg::*;
;
  logic             valid;
  logic             ready;
  logic [VAL_W-1:0] filtered_value;
  logic [VAL_W-1:0] calibrated_sample;
  logic             cal_fault;

  modport source (output valid, output filtered_value, output calibrated_sample,
                  output cal_fault, input ready);
  modport sink   (input valid, input filtered_value, input calibrated_sample,
                  input cal_fault, output ready);
endinterface

// ===== design/adc_two_point_cal_moving_average.sv =====
// Each sample runs ST_MUL (bit-serial multiply) and ST_DIV (divide by the raw span), then
// ST_CAL, ST_UPD, ST_AVG (window sum divided by WINDOW_LEN) and ST_WB; ST_AVG drops out in
// bypass mode. A calibration fault skips the multiply and divide.
// A new sample is taken only in ST_IDLE, after the last result has moved into the output
// register, so the bit-serial multiply and shared restoring divider set the sample spacing.
// Reset: synchronous, active low; control and configuration registers reset, ring reads zero.
// ----------------------------------------------------------------------------
// adc_two_point_cal_moving_average
// Two-point linear calibration of raw converter samples followed by a
// moving-average window, built around a shift-add multiplier and a
// bit-serial restoring divider shared by both divisions.
// ----------------------------------------------------------------------------
`include "adc_two_point_cal_moving_average_defines.svh"

module adc_two_point_cal_moving_average import adccal_pkg::*; #(
  parameter int WINDOW_LEN  = 16,
  parameter int SAMPLE_BITS = 10
) (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  cfg_we,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_data,
  adccal_in_if.sink             in_ch,
  adccal_out_if.source          out_ch
);

  // Derived widths.
  localparam int DIFF_W = ((SAMPLE_BITS > RAWCAL_W) ? SAMPLE_BITS : RAWCAL_W) + 1;
  localparam int MAGA_W = DIFF_W - 1;
  localparam int NUM_W  = MAGA_W + VAL_W;
  localparam int SUM_W  = VAL_W + $clog2(WINDOW_LEN);
  localparam int DVD_W  = (NUM_W > SUM_W) ? NUM_W : SUM_W;
  localparam int WLB_W  = $clog2(WINDOW_LEN + 1);
  localparam int DSR_W  = (RAWCAL_W > WLB_W) ? RAWCAL_W : WLB_W;
  localparam int CNT_W  = $clog2(DVD_W + 1);
  localparam int PTR_W  = $clog2(WINDOW_LEN);

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_MUL,
    ST_DIV,
    ST_CAL,
    ST_UPD,
    ST_AVG,
    ST_WB
  } state_t;

  // Configuration registers.
  logic [RAWCAL_W-1:0] raw_cal_low_r;
  logic [RAWCAL_W-1:0] raw_cal_high_r;
  logic [VAL_W-1:0]    value_at_low_r;
  logic [VAL_W-1:0]    value_at_high_r;
  logic                average_bypass_r;

  // Control and datapath registers.
  state_t              state_r;
  logic [CNT_W-1:0]    cnt_r;
  logic [DVD_W-1:0]    dvd_r;
  logic [DSR_W-1:0]    dsr_r;
  logic [DSR_W-1:0]    rem_r;
  logic [VAL_W-1:0]    mul_r;
  logic [MAGA_W-1:0]   maga_r;
  logic                neg_r;
  logic                fault_r;
  logic [VAL_W-1:0]    cal_r;
  logic [SUM_W-1:0]    sum_r;
  logic [PTR_W-1:0]    ptr_r;
  logic [WINDOW_LEN-1:0] vld_r;
  logic [VAL_W-1:0]    rd_r;

  // Output register.
  logic                out_valid_r;
  logic [VAL_W-1:0]    out_filt_r;
  logic [VAL_W-1:0]    out_cal_r;
  logic                out_fault_r;

  // Sample ring.
  logic [VAL_W-1:0]    ring_mem [WINDOW_LEN];

  // Combinational values.
  logic                in_xfer;
  logic                out_xfer;
  logic [DIFF_W-1:0]   diff;
  logic [MAGA_W-1:0]   maga;
  logic [VAL_W:0]      dv;
  logic [VAL_W-1:0]    magv;
  logic [RAWCAL_W:0]   den;
  logic [RAWCAL_W-1:0] magd;
  logic [DSR_W:0]      rem_sh;
  logic                step_ge;
  logic [DSR_W:0]      trial;
  logic [DSR_W-1:0]    rem_nxt;
  logic [DVD_W-1:0]    dvd_div_nxt;
  logic [DVD_W-1:0]    dvd_mul_nxt;
  logic [VAL_W-1:0]    qmag;
  logic [VAL_W-1:0]    q16;
  logic [VAL_W-1:0]    old_val;
  logic [SUM_W-1:0]    sum_nxt;
  logic                last_step;
  logic                div_busy;
  logic                serial_busy;
  logic                wb_load;
  logic                wb_done;

  assign in_xfer  = in_ch.valid && in_ch.ready;
  assign out_xfer = out_ch.valid && out_ch.ready;

  assign in_ch.ready              = (state_r == ST_IDLE);
  assign out_ch.valid             = out_valid_r;
  assign out_ch.filtered_value    = out_filt_r;
  assign out_ch.calibrated_sample = out_cal_r;
  assign out_ch.cal_fault         = out_fault_r;

  // Phase flags used by the sequencer and the checks.
  assign div_busy    = (state_r == ST_DIV) || (state_r == ST_AVG);
  assign serial_busy = (state_r == ST_MUL) || div_busy;
  assign wb_load     = (state_r == ST_WB) && (!out_valid_r || out_ch.ready);
  assign wb_done     = out_valid_r && (state_r == ST_IDLE);

  // Signed differences of the formula, split into magnitudes and one sign.
  always_comb begin
    diff = DIFF_W'(in_ch.raw_sample) - DIFF_W'(raw_cal_low_r);
    maga = diff[DIFF_W-1] ? MAGA_W'(-diff) : diff[MAGA_W-1:0];
    dv   = (VAL_W+1)'(value_at_high_r) - (VAL_W+1)'(value_at_low_r);
    magv = dv[VAL_W] ? VAL_W'(-dv) : dv[VAL_W-1:0];
    den  = (RAWCAL_W+1)'(raw_cal_high_r) - (RAWCAL_W+1)'(raw_cal_low_r);
    magd = den[RAWCAL_W] ? RAWCAL_W'(-den) : den[RAWCAL_W-1:0];
  end

  // One step of the shift-add multiplier, most significant bit first.
  assign dvd_mul_nxt = (dvd_r << 1) + (mul_r[VAL_W-1] ? DVD_W'(maga_r) : '0);

  // One step of the restoring divider; quotient bits enter at the bottom.
  always_comb begin
    rem_sh      = {rem_r, dvd_r[DVD_W-1]};
    step_ge     = (rem_sh >= {1'b0, dsr_r});
    trial       = rem_sh - {1'b0, dsr_r};
    rem_nxt     = step_ge ? trial[DSR_W-1:0] : rem_sh[DSR_W-1:0];
    dvd_div_nxt = {dvd_r[DVD_W-2:0], step_ge};
  end

  // Signed quotient and window sum update.
  always_comb begin
    qmag    = dvd_r[VAL_W-1:0];
    q16     = neg_r ? VAL_W'(-qmag) : qmag;
    old_val = vld_r[ptr_r] ? rd_r : '0;
    sum_nxt = sum_r - SUM_W'(old_val) + SUM_W'(cal_r);
  end

  assign last_step = (cnt_r == CNT_W'(1));

  // Configuration writes; indexes beyond the list are ignored.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      raw_cal_low_r    <= RAWCAL_W'(0);
      raw_cal_high_r   <= RAWCAL_W'(1023);
      value_at_low_r   <= VAL_W'(800);
      value_at_high_r  <= VAL_W'(4200);
      average_bypass_r <= 1'b0;
    end else if (cfg_we) begin
      unique case (cfg_idx_t'(cfg_index))
        CFG_RAW_CAL_LOW:    raw_cal_low_r    <= cfg_data[RAWCAL_W-1:0];
        CFG_RAW_CAL_HIGH:   raw_cal_high_r   <= cfg_data[RAWCAL_W-1:0];
        CFG_VALUE_AT_LOW:   value_at_low_r   <= cfg_data[VAL_W-1:0];
        CFG_VALUE_AT_HIGH:  value_at_high_r  <= cfg_data[VAL_W-1:0];
        CFG_AVERAGE_BYPASS: average_bypass_r <= cfg_data[0];
        default: begin
        end
      endcase
    end
  end

  // Ring memory: written after each calibration, read at the pointer every cycle.
  always_ff @(posedge clk) begin
    if (state_r == ST_UPD) begin
      ring_mem[ptr_r] <= cal_r;
    end
    rd_r <= ring_mem[ptr_r];
  end

  // Sequencer, datapath and output register.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      cnt_r       <= '0;
      sum_r       <= '0;
      ptr_r       <= '0;
      vld_r       <= '0;
      out_valid_r <= 1'b0;
    end else begin
      if (out_xfer && !wb_load) begin
        out_valid_r <= 1'b0;
      end
      unique case (state_r)
        ST_IDLE: begin
          if (in_xfer) begin
            dvd_r   <= '0;
            mul_r   <= magv;
            maga_r  <= maga;
            dsr_r   <= DSR_W'(magd);
            neg_r   <= diff[DIFF_W-1] ^ dv[VAL_W] ^ den[RAWCAL_W];
            fault_r <= (den == '0);
            cnt_r   <= CNT_W'(VAL_W);
            state_r <= (den == '0) ? ST_CAL : ST_MUL;
          end
        end
        ST_MUL: begin
          dvd_r <= dvd_mul_nxt;
          mul_r <= mul_r << 1;
          if (last_step) begin
            rem_r   <= '0;
            cnt_r   <= CNT_W'(DVD_W);
            state_r <= ST_DIV;
          end else begin
            cnt_r <= cnt_r - CNT_W'(1);
          end
        end
        ST_DIV: begin
          dvd_r <= dvd_div_nxt;
          rem_r <= rem_nxt;
          cnt_r <= cnt_r - CNT_W'(1);
          if (last_step) begin
            state_r <= ST_CAL;
          end
        end
        ST_CAL: begin
          cal_r   <= fault_r ? value_at_low_r : q16 + value_at_low_r;
          state_r <= ST_UPD;
        end
        ST_UPD: begin
          sum_r        <= sum_nxt;
          vld_r[ptr_r] <= 1'b1;
          ptr_r        <= (ptr_r == PTR_W'(WINDOW_LEN - 1)) ? '0 : ptr_r + PTR_W'(1);
          if (average_bypass_r) begin
            state_r <= ST_WB;
          end else begin
            dvd_r   <= DVD_W'(sum_nxt) << (DVD_W - SUM_W);
            dsr_r   <= DSR_W'(WINDOW_LEN);
            rem_r   <= '0;
            cnt_r   <= CNT_W'(SUM_W);
            state_r <= ST_AVG;
          end
        end
        ST_AVG: begin
          dvd_r <= dvd_div_nxt;
          rem_r <= rem_nxt;
          cnt_r <= cnt_r - CNT_W'(1);
          if (last_step) begin
            state_r <= ST_WB;
          end
        end
        ST_WB: begin
          if (wb_load) begin
            out_valid_r <= 1'b1;
            out_filt_r  <= average_bypass_r ? cal_r : dvd_r[VAL_W-1:0];
            out_cal_r   <= cal_r;
            out_fault_r <= fault_r;
            state_r     <= ST_IDLE;
          end
        end
        default: begin
          state_r <= ST_IDLE;
        end
      endcase
    end
  end

  // The partial remainder stays below the divisor throughout a division.
  `ADCCAL_ASSERT_NOW(a_rem_below_dsr, clk, rst_n, div_busy, (rem_r < dsr_r), "remainder overflow")

  // Serial stages never run with an exhausted step counter.
  `ADCCAL_ASSERT_NOW(a_cnt_live, clk, rst_n, serial_busy, (cnt_r != '0), "step counter ran out")

  // A finished result with a free output register is presented next cycle.
  `ADCCAL_ASSERT_NEXT(a_wb_load, clk, rst_n, wb_load, wb_done, "result not loaded")

  // Ring valid bits are only ever set, never cleared, outside reset.
  `ADCCAL_ASSERT_NEXT(a_vld_grow, clk, rst_n, 1'b1, (&(vld_r | ~$past(vld_r))), "valid bit lost")

endmodule

// ===== tb/adc_two_point_cal_moving_average_test.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// adc_two_point_cal_moving_average_test
// Self-checking bench for one calibration channel. A short table of register
// writes and raw samples comes first, then randomised phases of register
// settings, each followed by a run of raw samples. Every result transfer is
// checked field by field against the table or a model of the two-point
// calibration and 16-entry moving average; random idling ends at phase 11.
// ----------------------------------------------------------------------------
module adc_two_point_cal_moving_average_test;
  import adccal_pkg::*;

  localparam int SAMPLE_BITS     = 10;
  localparam int RING_LEN        = 16;
  localparam int RANDOM_PHASES   = 16;
  localparam int ITEMS_PER_PHASE = 100;
  localparam int STALL_LIMIT     = 4000;
  localparam int TAIL_CYCLES     = 200;
  localparam logic [CFG_IDX_W-1:0] CFG_IDX_UNUSED_LO = CFG_IDX_W'(CFG_AVERAGE_BYPASS + 1);
  localparam logic [CFG_IDX_W-1:0] CFG_IDX_UNUSED_HI = '1;

  typedef struct packed {
    logic [VAL_W-1:0] filtered_value;
    logic [VAL_W-1:0] calibrated_sample;
    logic             cal_fault;
  } reading_t;

  typedef enum logic {ROW_WRITE, ROW_SAMPLE} row_kind_t;

  typedef struct packed {
    row_kind_t              kind;
    logic [CFG_IDX_W-1:0]   index;
    logic [CFG_DATA_W-1:0]  data;
    logic [SAMPLE_BITS-1:0] raw;
    logic                   has_expected;
    reading_t               reading;
  } stim_row_t;

  logic                  clk;
  logic                  rst_n;
  logic                  cfg_we;
  logic [CFG_IDX_W-1:0]  cfg_index;
  logic [CFG_DATA_W-1:0] cfg_data;

  adccal_in_if #(.SAMPLE_BITS(SAMPLE_BITS)) in_ch ();
  adccal_out_if out_ch ();

  adc_two_point_cal_moving_average #(
    .WINDOW_LEN (RING_LEN),
    .SAMPLE_BITS(SAMPLE_BITS)
  ) dut (
    .clk      (clk),
    .rst_n    (rst_n),
    .cfg_we   (cfg_we),
    .cfg_index(cfg_index),
    .cfg_data (cfg_data),
    .in_ch    (in_ch),
    .out_ch   (out_ch)
  );

  // Shadow copy of the calibration registers, at their reset values.
  logic [RAWCAL_W-1:0] cal_raw_low    = '0;
  logic [RAWCAL_W-1:0] cal_raw_high   = 10'd1023;
  logic [VAL_W-1:0]    cal_value_low  = 16'd800;
  logic [VAL_W-1:0]    cal_value_high = 16'd4200;
  logic                cal_bypass     = 1'b0;

  // Model of the averaging window.
  logic [VAL_W-1:0] window_ring [RING_LEN];
  logic [3:0]       window_slot = '0;
  logic [19:0]      window_total = '0;

  reading_t  expected_readings [$];
  stim_row_t stim_table [$];
  int        mismatches    = 0;
  int        stall_cycles  = 0;
  int        send_idle_pct = 23;
  int        recv_idle_pct = 77;

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // Calibrate one raw sample, push it through the window and form the result.
  function automatic reading_t calibrate_and_average(input logic [SAMPLE_BITS-1:0] raw);
    reading_t   r;
    longint     span;
    longint     scaled;
    longint     mapped;
    logic [VAL_W-1:0] cal;
    span = longint'(cal_raw_high) - longint'(cal_raw_low);
    if (span == 0) begin
      cal = cal_value_low;
      r.cal_fault = 1'b1;
    end else begin
      scaled = (longint'(raw) - longint'(cal_raw_low)) *
               (longint'(cal_value_high) - longint'(cal_value_low));
      mapped = scaled / span + longint'(cal_value_low);
      cal = mapped[VAL_W-1:0];
      r.cal_fault = 1'b0;
    end
    window_total = window_total - window_ring[window_slot] + cal;
    window_ring[window_slot] = cal;
    window_slot = window_slot + 1'b1;
    r.calibrated_sample = cal;
    r.filtered_value = cal_bypass ? cal : window_total[19:4];
    return r;
  endfunction

  // Register writes happen only once every outstanding result has arrived.
  task automatic write_cal_reg(input logic [CFG_IDX_W-1:0] idx,
                               input logic [CFG_DATA_W-1:0] data);
    in_ch.valid <= 1'b0;
    while (expected_readings.size() != 0) @(posedge clk);
    @(posedge clk);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= data;
    case (idx)
      CFG_RAW_CAL_LOW:    cal_raw_low    = data[RAWCAL_W-1:0];
      CFG_RAW_CAL_HIGH:   cal_raw_high   = data[RAWCAL_W-1:0];
      CFG_VALUE_AT_LOW:   cal_value_low  = data[VAL_W-1:0];
      CFG_VALUE_AT_HIGH:  cal_value_high = data[VAL_W-1:0];
      CFG_AVERAGE_BYPASS: cal_bypass     = data[0];
      default: ;
    endcase
    @(posedge clk);
    cfg_we <= 1'b0;
  endtask

  // Offer one raw sample after a random gap and record what it should produce.
  task automatic send_raw(input logic [SAMPLE_BITS-1:0] raw, input logic has_expected,
                          input reading_t typed_reading);
    reading_t predicted;
    while ($urandom_range(99) < send_idle_pct) begin
      in_ch.valid <= 1'b0;
      @(posedge clk);
    end
    in_ch.valid      <= 1'b1;
    in_ch.raw_sample <= raw;
    do @(posedge clk); while (!in_ch.ready);
    predicted = calibrate_and_average(raw);
    expected_readings.push_back(has_expected ? typed_reading : predicted);
  endtask

  task automatic add_write(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DATA_W-1:0] data);
    stim_table.push_back('{ROW_WRITE, idx, data, '0, 1'b0, '0});
  endtask

  task automatic add_sample(input logic [SAMPLE_BITS-1:0] raw);
    stim_table.push_back('{ROW_SAMPLE, '0, '0, raw, 1'b0, '0});
  endtask

  task automatic add_typed(input logic [SAMPLE_BITS-1:0] raw, input logic [VAL_W-1:0] filt,
                           input logic [VAL_W-1:0] cal, input logic fault);
    reading_t r;
    r.filtered_value    = filt;
    r.calibrated_sample = cal;
    r.cal_fault         = fault;
    stim_table.push_back('{ROW_SAMPLE, '0, '0, raw, 1'b1, r});
  endtask

  // Pick a register value: an extreme, an in-range value or a full-width one.
  function automatic logic [CFG_DATA_W-1:0] pick_cfg_value();
    case ($urandom_range(3))
      0:       return '0;
      1:       return '1;
      2:       return CFG_DATA_W'($urandom_range(1023));
      default: return CFG_DATA_W'($urandom);
    endcase
  endfunction

  // Raw samples favour the range ends and the calibration points.
  function automatic logic [SAMPLE_BITS-1:0] next_raw();
    case ($urandom_range(7))
      0:       return '0;
      1:       return '1;
      2:       return cal_raw_low;
      3:       return cal_raw_high;
      default: return SAMPLE_BITS'($urandom);
    endcase
  endfunction

  // Compare one result transfer with the oldest expectation.
  task automatic check_reading();
    reading_t want;
    if (expected_readings.size() == 0) begin
      mismatches++;
      $display("%0t: result transfer with none expected, got %0d/%0d/%0d", $time,
               out_ch.filtered_value, out_ch.calibrated_sample, out_ch.cal_fault);
    end else begin
      want = expected_readings.pop_front();
      if (out_ch.filtered_value !== want.filtered_value) begin
        mismatches++;
        $display("%0t: filtered_value expected %0d, got %0d", $time,
                 want.filtered_value, out_ch.filtered_value);
      end
      if (out_ch.calibrated_sample !== want.calibrated_sample) begin
        mismatches++;
        $display("%0t: calibrated_sample expected %0d, got %0d", $time,
                 want.calibrated_sample, out_ch.calibrated_sample);
      end
      if (out_ch.cal_fault !== want.cal_fault) begin
        mismatches++;
        $display("%0t: cal_fault expected %0d, got %0d", $time,
                 want.cal_fault, out_ch.cal_fault);
      end
    end
  endtask

  // Result side: check each transfer, then decide whether to stall next cycle.
  always @(posedge clk) begin
    if (rst_n && out_ch.valid && out_ch.ready) check_reading();
    out_ch.ready <= ($urandom_range(99) >= recv_idle_pct);
  end

  // Count cycles in which neither channel completes a transfer.
  always @(posedge clk) begin
    if (!rst_n || (in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready))
      stall_cycles <= 0;
    else
      stall_cycles <= stall_cycles + 1;
  end

  initial begin
    wait (stall_cycles >= STALL_LIMIT);
    $display("adc_two_point_cal_moving_average_test failed");
    $finish;
  end

  initial begin
    reading_t              no_reading;
    logic [CFG_DATA_W-1:0] raw_lo;
    logic [CFG_DATA_W-1:0] raw_hi;
    logic [CFG_DATA_W-1:0] val_lo;
    logic [CFG_DATA_W-1:0] val_hi;
    logic [CFG_DATA_W-1:0] bypass;
    no_reading = '0;
    foreach (window_ring[k]) window_ring[k] = '0;
    rst_n            <= 1'b0;
    cfg_we           <= 1'b0;
    cfg_index        <= CFG_RAW_CAL_LOW;
    cfg_data         <= '0;
    in_ch.valid      <= 1'b0;
    in_ch.raw_sample <= '0;
    repeat (8) @(posedge clk);
    rst_n <= 1'b1;

    // Directed part, starting from the reset settings.
    add_typed(10'd0,    16'd50,    16'd800,   1'b0);
    add_typed(10'd1023, 16'd312,   16'd4200,  1'b0);
    add_sample(10'd512);
    add_write(CFG_AVERAGE_BYPASS, 16'd1);
    add_typed(10'd0,    16'd800,   16'd800,   1'b0);
    add_typed(10'd1023, 16'd4200,  16'd4200,  1'b0);
    // Equal raw points: the low value comes out with the fault flag.
    add_write(CFG_RAW_CAL_HIGH, 16'd0);
    add_typed(10'd0,    16'd800,   16'd800,   1'b1);
    add_typed(10'd1023, 16'd800,   16'd800,   1'b1);
    add_write(CFG_VALUE_AT_LOW, 16'hFFFF);
    add_typed(10'd777,  16'hFFFF,  16'hFFFF,  1'b1);
    // Fault value still enters the window with bypass cleared.
    add_write(CFG_AVERAGE_BYPASS, 16'd0);
    add_sample(10'd5);
    // Falling slope; the wide write keeps only the low ten bits.
    add_write(CFG_RAW_CAL_LOW, 16'hFFFF);
    add_write(CFG_VALUE_AT_HIGH, 16'd0);
    add_sample(10'd0);
    add_sample(10'd1023);
    add_write(CFG_RAW_CAL_HIGH, 16'hFC01);
    add_sample(10'd511);
    add_sample(10'd0);
    // Writes to unused indexes must leave every register alone.
    add_write(CFG_IDX_UNUSED_LO, 16'h0000);
    add_write(CFG_IDX_UNUSED_HI, 16'hFFFF);
    add_sample(10'd1023);
    add_write(CFG_RAW_CAL_LOW, 16'd0);
    add_write(CFG_RAW_CAL_HIGH, 16'd1023);
    add_write(CFG_VALUE_AT_LOW, 16'd0);
    add_write(CFG_VALUE_AT_HIGH, 16'hFFFF);
    add_sample(10'd1);
    add_sample(10'd1023);

    foreach (stim_table[i]) begin
      if (stim_table[i].kind == ROW_WRITE)
        write_cal_reg(stim_table[i].index, stim_table[i].data);
      else
        send_raw(stim_table[i].raw, stim_table[i].has_expected, stim_table[i].reading);
    end

    // Random phases: the first four fix the extremes, the rest are drawn.
    for (int phase = 0; phase < RANDOM_PHASES; phase++) begin
      if (phase == 6) begin
        send_idle_pct = 77;
        recv_idle_pct = 23;
      end else if (phase == 11) begin
        send_idle_pct = 0;
        recv_idle_pct = 0;
      end
      case (phase)
        0: begin
          raw_lo = '0; raw_hi = '0; val_lo = '0; val_hi = '0; bypass = '0;
        end
        1: begin
          raw_lo = '1; raw_hi = '1; val_lo = '1; val_hi = '1; bypass = '1;
        end
        2: begin
          raw_lo = '0; raw_hi = '1; val_lo = '0; val_hi = '1; bypass = '0;
        end
        3: begin
          raw_lo = '1; raw_hi = '0; val_lo = '1; val_hi = '0; bypass = '1;
        end
        default: begin
          raw_lo = pick_cfg_value();
          raw_hi = ($urandom_range(5) == 0) ? raw_lo : pick_cfg_value();
          val_lo = pick_cfg_value();
          val_hi = pick_cfg_value();
          bypass = CFG_DATA_W'($urandom);
        end
      endcase
      write_cal_reg(CFG_RAW_CAL_LOW, raw_lo);
      write_cal_reg(CFG_RAW_CAL_HIGH, raw_hi);
      write_cal_reg(CFG_VALUE_AT_LOW, val_lo);
      write_cal_reg(CFG_VALUE_AT_HIGH, val_hi);
      write_cal_reg(CFG_AVERAGE_BYPASS, bypass);
      if ($urandom_range(1) == 0)
        write_cal_reg(CFG_IDX_W'($urandom_range(CFG_IDX_UNUSED_LO, CFG_IDX_UNUSED_HI)),
                      CFG_DATA_W'($urandom));
      for (int n = 0; n < ITEMS_PER_PHASE; n++) send_raw(next_raw(), 1'b0, no_reading);
    end

    // Drain, then give any stray result time to show up.
    in_ch.valid <= 1'b0;
    while (expected_readings.size() != 0) @(posedge clk);
    repeat (TAIL_CYCLES) @(posedge clk);
    if (mismatches == 0)
      $display("adc_two_point_cal_moving_average_test passed");
    else
      $display("adc_two_point_cal_moving_average_test failed");
    $finish;
  end

endmodule
